FILE: rtl/rpvc_pkg.sv
package rpvc_pkg;

    // build constants
    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 16;
    localparam int GUARD_BITS    = 4;

    localparam int VAL_W      = 32;
    localparam int DW         = VAL_W + GUARD_BITS + 4;   // cordic x/y width
    localparam int ZCW        = 35;                       // cordic angle width, q30
    localparam int DEG_SHIFT  = 7 + FRAC_BITS;
    localparam int ANG_SHIFT  = 30 - FRAC_BITS;
    localparam int DEG_PW     = 65;                       // degree product width
    localparam int ZW         = DEG_PW - DEG_SHIFT;       // radian angle width
    localparam int NMOD       = ZW - 32;                  // modulo 2pi steps
    localparam int GAIN_SHIFT = 24 + GUARD_BITS;
    localparam int GP_W       = DW + 25;                  // gain product width

    localparam logic signed [32:0] DEG_TO_RAD_Q37 = 33'sd2398762259;
    localparam logic signed [24:0] GAIN_Q24       = 25'sd10187995;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;

    // form selector codes
    localparam logic [1:0] OP_RECT  = 2'd0;
    localparam logic [1:0] OP_POLAR = 2'd1;
    localparam logic [1:0] OP_BAD2  = 2'd2;
    localparam logic [1:0] OP_BAD3  = 2'd3;

    // item fields that ride along the pipeline
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] ang_pol;
    } t_side;

    typedef struct packed {
        logic signed [DW-1:0]  x;
        logic signed [DW-1:0]  y;
        logic signed [ZCW-1:0] z;
    } t_vec;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // atan(2^-i) in q30
    function automatic logic [ZCW-1:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            5'd31: v = 32'h00000000;
        endcase
        return ZCW'(v);
    endfunction

endpackage

FILE: rtl/rpvc_prep.sv
module rpvc_prep
    import rpvc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_vld,
    output t_vec        o_vec,
    output t_side       o_side
);

    localparam logic signed [DEG_PW-1:0] DEG_HALF = DEG_PW'(64'sd1 <<< (DEG_SHIFT - 1));
    localparam logic signed [ZW-1:0]     ANG_HALF = ZW'(64'sd1 <<< (ANG_SHIFT - 1));
    localparam logic [ZW:0]              TWO_PI_U = (ZW + 1)'(TWO_PI_Q30);
    localparam logic [ZW:0]              PI_U     = (ZW + 1)'(PI_Q30);
    localparam logic signed [ZCW-1:0]    HALF_S   = ZCW'(HALF_PI_Q30);
    localparam logic signed [ZCW-1:0]    TWO_S    = ZCW'(TWO_PI_Q30);

    // input register
    logic r_v0;
    t_side r_sd0;
    // degree product
    logic r_v1;
    t_side r_sd1;
    logic signed [DEG_PW-1:0] r_prod;
    // q30 angle
    logic r_v2;
    t_side r_sd2;
    logic signed [ZW-1:0] r_zr;
    // magnitude and sign of angle
    logic r_v3;
    t_side r_sd3;
    logic [ZW:0] r_u3;
    logic r_neg3;
    // modulo chain
    logic        r_mv   [NMOD];
    t_side       r_msd  [NMOD];
    logic [ZW:0] r_mu   [NMOD];
    logic        r_mneg [NMOD];
    // reduced angle
    logic r_v4;
    t_side r_sd4;
    logic signed [ZCW-1:0] r_z4;
    // start vector
    logic r_v5;
    t_side r_sd5;
    t_vec r_vec5;

    logic signed [DEG_PW-1:0] n_prod;
    logic signed [ZW-1:0]     n_zr;
    logic signed [ZW-1:0]     n_ang;
    logic [ZW:0]              n_u3;
    t_side                    n_sd3;
    logic [ZW:0]              u_last;
    logic signed [ZCW-1:0]    n_z4;
    t_vec                     n_vec5;
    logic signed [DW-1:0]     ag;
    logic signed [DW-1:0]     bg;

    assign n_prod = DEG_PW'(r_sd0.b) * DEG_PW'(DEG_TO_RAD_Q37);
    assign n_zr   = ZW'((r_prod + DEG_HALF) >>> DEG_SHIFT);
    assign n_ang  = (r_zr + ANG_HALF) >>> ANG_SHIFT;
    assign n_u3   = r_zr[ZW-1] ? (ZW + 1)'(-(ZW + 1)'(r_zr)) : (ZW + 1)'(r_zr);

    // polar angle output rides along with the item
    always_comb begin
        n_sd3         = r_sd2;
        n_sd3.ang_pol = sat32(64'(n_ang));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_vld;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd0.op      <= i_op;
            r_sd0.a       <= i_a;
            r_sd0.b       <= i_b;
            r_sd0.ang_pol <= '0;
            r_sd1         <= r_sd0;
            r_prod        <= n_prod;
            r_sd2         <= r_sd1;
            r_zr          <= n_zr;
            r_sd3         <= n_sd3;
            r_u3          <= n_u3;
            r_neg3        <= r_zr[ZW-1];
        end
    end

    // restoring reduction of |angle| by 2pi, one quotient bit per stage
    for (genvar j = 0; j < NMOD; j++) begin : g_mod
        logic [ZW:0] u_in;
        logic [ZW:0] c;
        logic        v_in;
        t_side       sd_in;
        logic        neg_in;
        if (j == 0) begin : g_first
            assign u_in   = r_u3;
            assign v_in   = r_v3;
            assign sd_in  = r_sd3;
            assign neg_in = r_neg3;
        end else begin : g_next
            assign u_in   = r_mu[j-1];
            assign v_in   = r_mv[j-1];
            assign sd_in  = r_msd[j-1];
            assign neg_in = r_mneg[j-1];
        end
        assign c = TWO_PI_U << (NMOD - 1 - j);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv[j] <= 1'b0;
            end else if (i_en) begin
                r_mv[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_msd[j]  <= sd_in;
                r_mneg[j] <= neg_in;
                r_mu[j]   <= (u_in >= c) ? u_in - c : u_in;
            end
        end
    end

    assign u_last = r_mu[NMOD-1];

    // fold into (-pi, pi]
    always_comb begin
        if (r_mneg[NMOD-1]) begin
            n_z4 = (u_last < PI_U) ? -ZCW'(u_last) : TWO_S - ZCW'(u_last);
        end else begin
            n_z4 = (u_last > PI_U) ? ZCW'(u_last) - TWO_S : ZCW'(u_last);
        end
    end

    assign ag = DW'(r_sd4.a) <<< GUARD_BITS;
    assign bg = DW'(r_sd4.b) <<< GUARD_BITS;

    // quarter turn so the cordic works inside +-pi/2
    always_comb begin
        n_vec5.x = ag;
        n_vec5.y = bg;
        n_vec5.z = '0;
        if (r_sd4.op == OP_POLAR) begin
            n_vec5.y = '0;
            n_vec5.z = r_z4;
            if (r_z4 > HALF_S) begin
                n_vec5.x = '0;
                n_vec5.y = ag;
                n_vec5.z = r_z4 - HALF_S;
            end else if (r_z4 < -HALF_S) begin
                n_vec5.x = '0;
                n_vec5.y = -ag;
                n_vec5.z = r_z4 + HALF_S;
            end
        end else if (r_sd4.a[31]) begin
            if (!r_sd4.b[31]) begin
                n_vec5.x = bg;
                n_vec5.y = -ag;
                n_vec5.z = HALF_S;
            end else begin
                n_vec5.x = -bg;
                n_vec5.y = ag;
                n_vec5.z = -HALF_S;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_mv[NMOD-1];
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd4  <= r_msd[NMOD-1];
            r_z4   <= n_z4;
            r_sd5  <= r_sd4;
            r_vec5 <= n_vec5;
        end
    end

    assign o_vld  = r_v5;
    assign o_vec  = r_vec5;
    assign o_side = r_sd5;

endmodule

FILE: rtl/rpvc_cordic.sv
module rpvc_cordic
    import rpvc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_vec  i_vec,
    input  t_side i_side,
    output logic  o_vld,
    output t_vec  o_vec,
    output t_side o_side
);

    logic  r_vld [CORDIC_STAGES];
    t_vec  r_vec [CORDIC_STAGES];
    t_side r_sd  [CORDIC_STAGES];

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
        logic  v_in;
        t_vec  vec_in;
        t_side sd_in;
        logic  cw;
        t_vec  n_vec;
        logic signed [DW-1:0] xs;
        logic signed [DW-1:0] ys;
        logic [ZCW-1:0]       at;
        if (s == 0) begin : g_first
            assign v_in   = i_vld;
            assign vec_in = i_vec;
            assign sd_in  = i_side;
        end else begin : g_next
            assign v_in   = r_vld[s-1];
            assign vec_in = r_vec[s-1];
            assign sd_in  = r_sd[s-1];
        end

        assign xs = vec_in.x >>> s;
        assign ys = vec_in.y >>> s;
        assign at = atan_q30(5'(s));
        // rotation drives z to zero, vectoring drives y to zero
        assign cw = (sd_in.op == OP_POLAR) ? vec_in.z[ZCW-1] : !vec_in.y[DW-1];

        always_comb begin
            if (cw) begin
                n_vec.x = vec_in.x + ys;
                n_vec.y = vec_in.y - xs;
                n_vec.z = vec_in.z + $signed(at);
            end else begin
                n_vec.x = vec_in.x - ys;
                n_vec.y = vec_in.y + xs;
                n_vec.z = vec_in.z - $signed(at);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_vec[s] <= n_vec;
                r_sd[s]  <= sd_in;
            end
        end
    end

    assign o_vld  = r_vld[CORDIC_STAGES-1];
    assign o_vec  = r_vec[CORDIC_STAGES-1];
    assign o_side = r_sd[CORDIC_STAGES-1];

endmodule

FILE: rtl/rpvc_post.sv
module rpvc_post
    import rpvc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_vld,
    input  t_vec         i_vec,
    input  t_side        i_side,
    output logic         o_vld,
    output logic [127:0] o_data,
    output logic [1:0]   o_user
);

    localparam logic signed [GP_W-1:0] GAIN_HALF = GP_W'(64'sd1 <<< (GAIN_SHIFT - 1));
    localparam logic signed [ZCW-1:0]  ANG_HALF  = ZCW'(64'sd1 <<< (ANG_SHIFT - 1));

    logic r_v1;
    t_side r_sd1;
    logic signed [GP_W-1:0] r_px;
    logic signed [GP_W-1:0] r_py;
    logic signed [ZCW-1:0]  r_z1;

    logic         r_vld;
    logic [127:0] r_data;
    logic [1:0]   r_user;

    logic signed [GP_W-1:0] rx;
    logic signed [GP_W-1:0] ry;
    logic signed [ZCW-1:0]  zr;
    logic signed [31:0]     xo;
    logic signed [31:0]     yo;
    logic signed [31:0]     mag;
    logic signed [31:0]     ang;
    logic                   polar;
    logic                   bad;

    assign rx = (r_px + GAIN_HALF) >>> GAIN_SHIFT;
    assign ry = (r_py + GAIN_HALF) >>> GAIN_SHIFT;
    assign zr = (r_z1 + ANG_HALF) >>> ANG_SHIFT;

    always_comb begin
        xo    = '0;
        yo    = '0;
        mag   = '0;
        ang   = '0;
        polar = 1'b0;
        bad   = 1'b0;
        if (r_sd1.op == OP_RECT) begin
            xo = r_sd1.a;
            yo = r_sd1.b;
            // the zero vector has no direction
            if (r_sd1.a != '0 || r_sd1.b != '0) begin
                mag = rx[GP_W-1] ? '0 : sat32(64'(rx));
                ang = sat32(64'(zr));
            end
        end else if (r_sd1.op == OP_POLAR) begin
            xo    = sat32(64'(rx));
            yo    = sat32(64'(ry));
            mag   = r_sd1.a;
            ang   = r_sd1.ang_pol;
            polar = 1'b1;
        end else begin
            bad = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_v1  <= i_vld;
            r_vld <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd1  <= i_side;
            r_px   <= GP_W'(i_vec.x) * GP_W'(GAIN_Q24);
            r_py   <= GP_W'(i_vec.y) * GP_W'(GAIN_Q24);
            r_z1   <= i_vec.z;
            r_data <= {ang, mag, yo, xo};
            r_user <= {bad, polar};
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;
    assign o_user = r_user;

endmodule

FILE: rtl/rect_polar_vector_converter.sv
// channel  | dir | handshake              | tdata (low bit up)             | tuser
// ---------+-----+------------------------+--------------------------------+------------------
// input    | in  | i_s_tvalid / o_s_tready| first_value, second_value      | op
// result   | out | o_m_tvalid / i_m_tready| x_out, y_out, magnitude, angle | mode_polar, bad_form
//
// one transfer in and one out per clock while the receiver keeps taking results; an item passes
// through the input, degree product, angle and magnitude registers, the modulo 2pi chain, the
// reduced-angle and start-vector registers, the cordic rotation stages and the output registers
// synchronous active-low reset clears all valid bits, data registers are not reset
// the whole pipeline advances whenever the output register is empty or being taken;
// while a result waits, every stage holds and o_s_tready is low
module rect_polar_vector_converter
    import rpvc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [63:0]  i_s_tdata,   // first_value, second_value
    input  logic [1:0]   i_s_tuser,   // op
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,   // x_out, y_out, magnitude, angle_rad
    output logic [1:0]   o_m_tuser    // mode_polar, bad_form
);

    logic  en;
    logic  prep_vld;
    t_vec  prep_vec;
    t_side prep_sd;
    logic  cor_vld;
    t_vec  cor_vec;
    t_side cor_sd;

    // global advance: output register free or draining
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // angle scaling, modulo 2pi and quadrant fold
    rpvc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_op    (i_s_tuser),
        .i_a     (i_s_tdata[31:0]),
        .i_b     (i_s_tdata[63:32]),
        .o_vld   (prep_vld),
        .o_vec   (prep_vec),
        .o_side  (prep_sd)
    );

    // one micro-rotation per stage, vectoring or rotation per item
    rpvc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (prep_vld),
        .i_vec   (prep_vec),
        .i_side  (prep_sd),
        .o_vld   (cor_vld),
        .o_vec   (cor_vec),
        .o_side  (cor_sd)
    );

    // gain removal, rounding, saturation and the output register
    rpvc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (cor_vld),
        .i_vec   (cor_vec),
        .i_side  (cor_sd),
        .o_vld   (o_m_tvalid),
        .o_data  (o_m_tdata),
        .o_user  (o_m_tuser)
    );

endmodule

FILE: rtl/rpvc_chk.sv
module rpvc_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [63:0]  i_s_tdata,
    input logic [1:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [127:0] o_m_tdata,
    input logic [1:0]   o_m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // empty output never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with empty output");

    // stalled output freezes the pipe
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while result waits");

    // bad selector gives the zero vector in rectangular mode
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tdata == '0 && !o_m_tuser[0])
        else $error("bad form result not zero");

endmodule

bind rect_polar_vector_converter rpvc_chk u_rpvc_chk (.*);

FILE: verif/rpvc_checker.sv
module rpvc_checker
    import rpvc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [63:0]  i_s_tdata,   // first_value, second_value
    input  logic [1:0]   i_s_tuser,   // op
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [127:0] i_m_tdata,   // x_out, y_out, magnitude, angle_rad
    input  logic [1:0]   i_m_tuser,   // mode_polar, bad_form
    output int           o_errors,
    output int           o_pending,
    output int           o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] xo;
        logic [31:0] yo;
        logic [31:0] mag;
        logic [31:0] ang;
        logic        polar;
        logic        bad;
    } t_conv;

    t_conv conv_q[$];

    localparam longint ATAN_TAB[32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000};

    // >>> on longint is arithmetic, i.e. floor division
    function automatic longint rnd_shr(longint v, int s);
        return (s == 0) ? v : ((v + (64'sd1 <<< (s - 1))) >>> s);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint ungain(longint v);
        return rnd_shr(v * 64'sd10187995, 24 + GUARD_BITS);
    endfunction

    function automatic t_conv convert(logic [1:0] op, logic signed [31:0] av,
                                      logic signed [31:0] bv);
        t_conv  r;
        longint a, b, x, y, z, t, m;
        r = '0;
        a = av;
        b = bv;
        if (op == OP_RECT) begin
            r.xo = av;
            r.yo = bv;
            if (a != 0 || b != 0) begin
                x = a * 16;
                y = b * 16;
                z = 0;
                if (x < 0) begin
                    t = x;
                    if (y >= 0) begin
                        x = y; y = -t; z = HALF_PI_Q30;
                    end else begin
                        x = -y; y = t; z = -HALF_PI_Q30;
                    end
                end
                for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
                    t = x;
                    if (y >= 0) begin
                        x += y >>> i; y -= t >>> i; z += ATAN_TAB[i];
                    end else begin
                        x -= y >>> i; y += t >>> i; z -= ATAN_TAB[i];
                    end
                end
                m = ungain(x);
                if (m < 0) m = 0;
                if (m > 64'sd2147483647) m = 64'sd2147483647;
                r.mag = m[31:0];
                z = clip32(rnd_shr(z, 30 - FRAC_BITS));
                r.ang = z[31:0];
            end
        end else if (op == OP_POLAR) begin
            r.polar = 1'b1;
            z = rnd_shr(b * 64'sd2398762259, 7 + FRAC_BITS);
            r.mag = av;
            t = clip32(rnd_shr(z, 30 - FRAC_BITS));
            r.ang = t[31:0];
            z = z % TWO_PI_Q30;
            if (z < 0) z += TWO_PI_Q30;
            if (z > PI_Q30) z -= TWO_PI_Q30;
            x = a * 16;
            y = 0;
            if (z > HALF_PI_Q30) begin
                y = x; x = 0; z -= HALF_PI_Q30;
            end else if (z < -HALF_PI_Q30) begin
                y = -x; x = 0; z += HALF_PI_Q30;
            end
            for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
                t = x;
                if (z >= 0) begin
                    x -= y >>> i; y += t >>> i; z -= ATAN_TAB[i];
                end else begin
                    x += y >>> i; y -= t >>> i; z += ATAN_TAB[i];
                end
            end
            t = clip32(ungain(x));
            r.xo = t[31:0];
            t = clip32(ungain(y));
            r.yo = t[31:0];
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    assign o_pending = conv_q.size();

    initial begin
        o_errors = 0;
        o_results = 0;
    end

    always @(posedge i_clk) begin
        t_conv want, got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                conv_q.push_back(convert(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32]));
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[31:0], i_m_tdata[63:32], i_m_tdata[95:64],
                       i_m_tdata[127:96], i_m_tuser[0], i_m_tuser[1]};
                o_results <= o_results + 1;
                if (conv_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result transfer %h", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = conv_q.pop_front();
                    if (want !== got) begin
                        if (o_errors < 10)
                            $display("mismatch: x %h/%h y %h/%h mag %h/%h ang %h/%h pol %b/%b bad %b/%b",
                                     want.xo, got.xo, want.yo, got.yo, want.mag, got.mag,
                                     want.ang, got.ang, want.polar, got.polar,
                                     want.bad, got.bad);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/testbench.sv
module testbench;
    import rpvc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [63:0]  i_s_tdata = '0;   // first_value, second_value
    logic [1:0]   i_s_tuser = '0;   // op
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [127:0] o_m_tdata;        // x_out, y_out, magnitude, angle_rad
    logic [1:0]   o_m_tuser;        // mode_polar, bad_form

    int errors, pending, results;
    int cycles = 0;
    int send_idle_pct = 28;   // percent of cycles the sender holds off
    int recv_idle_pct = 82;   // percent of cycles the receiver stalls
    int n_items = 0;

    always #6 i_clk = ~i_clk;

    rect_polar_vector_converter uut (.*);

    rpvc_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // watchdog: ends the run as failed on timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stalls at random, changing on the falling edge
    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // one transfer on the input channel: random gap, then hold until taken
    task automatic send_item(logic [1:0] op, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {b, a};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        n_items++;
    endtask

    // mostly small-to-moderate values, sometimes the full range or extremes
    function automatic logic [31:0] pick_val();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            2: return 32'($signed($urandom_range(2000)) - 1000);
            default: return 32'($signed($urandom_range(32'h01000000)) - 32'sh00800000);
        endcase
    endfunction

    // angle in degrees, mostly within a few turns
    function automatic logic [31:0] pick_deg();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'(($signed($urandom_range(1440)) - 720) <<< 16);
            default: return 32'($signed($urandom_range(32'h05A00000)) - 32'sh02D00000);
        endcase
    endfunction

    task automatic random_phase(int n);
        logic [1:0] op;
        repeat (n) begin
            op = ($urandom_range(9) == 0) ? 2'($urandom_range(OP_BAD2, OP_BAD3))
                                          : 2'($urandom_range(1));
            if (op == OP_POLAR) send_item(op, pick_val(), pick_deg());
            else send_item(op, pick_val(), pick_val());
        end
        i_s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero vector, axes, extremes, special angles, bad selectors
        send_item(OP_RECT, 32'h0, 32'h0);
        send_item(OP_RECT, 32'h00010000, 32'h0);
        send_item(OP_RECT, 32'hffff0000, 32'h0);
        send_item(OP_RECT, 32'h0, 32'hffff0000);
        send_item(OP_RECT, 32'hffff0000, 32'h00010000);
        send_item(OP_RECT, 32'h7fffffff, 32'h7fffffff);
        send_item(OP_RECT, 32'h80000000, 32'h80000000);
        send_item(OP_RECT, 32'h80000000, 32'h7fffffff);
        send_item(OP_RECT, 32'h7fffffff, 32'h80000000);
        send_item(OP_POLAR, 32'h00010000, 32'h0);
        send_item(OP_POLAR, 32'h00010000, 32'h005a0000);
        send_item(OP_POLAR, 32'h00010000, 32'h00b40000);
        send_item(OP_POLAR, 32'h00010000, 32'hff4c0000);
        send_item(OP_POLAR, 32'hffff0000, 32'h002d0000);
        send_item(OP_POLAR, 32'h7fffffff, 32'h002d0000);
        send_item(OP_POLAR, 32'h80000000, 32'h7fffffff);
        send_item(OP_POLAR, 32'h7fffffff, 32'h80000000);
        send_item(OP_POLAR, 32'h00020000, 32'h01680000);
        send_item(OP_BAD2, 32'h12345678, 32'h9abcdef0);
        send_item(OP_BAD3, 32'hffffffff, 32'hffffffff);
        i_s_tvalid <= 1'b0;

        random_phase(380);
        send_idle_pct = 82;
        recv_idle_pct = 28;
        random_phase(380);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(390);

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("sent %0d items over rectangular, polar and invalid forms, %0d results checked",
                 n_items, results);
        $display("idle patterns: slow receiver, slow sender, then full rate");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/rpvc_pkg.sv
rtl/rpvc_prep.sv
rtl/rpvc_cordic.sv
rtl/rpvc_post.sv
rtl/rect_polar_vector_converter.sv
rtl/rpvc_chk.sv
verif/rpvc_checker.sv
verif/testbench.sv
